>>> rtl/core/h264fu_pkg.sv
// Shared constants, codes and types of the H.264 RTP FU-A packetizer.
package h264fu_pkg;

  localparam int unsigned DGM_W      = 14;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_PTR_W    = 1;
  localparam int unsigned Q_CNT_W    = 2;

  localparam logic [DGM_W-1:0] RTP_HDR_LEN = 14'd12;
  localparam logic [DGM_W-1:0] FU_OVERHEAD = 14'd14;  // RTP header plus FU indicator/header
  localparam logic [DGM_W-1:0] DGM_MIN     = 14'd1100;
  localparam logic [DGM_W-1:0] DGM_MAX     = 14'd9000;
  localparam logic [DGM_W-1:0] DGM_RESET   = 14'd1400;

  localparam logic [7:0] FU_A_TYPE  = 8'd28;
  localparam logic [7:0] NRI_F_MASK = 8'd224;
  localparam logic [7:0] TYPE_MASK  = 8'd31;

  localparam logic [1:0] HB_SINGLE = 2'd0;
  localparam logic [1:0] HB_FU_A   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DGM   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_START = 1'd1;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // One classified NAL unit, ready for the packet sequencer.
  typedef struct packed {
    logic [7:0]        hdr;
    logic [TS_W-1:0]   ts;
    logic              lof;
    logic              single;
    logic [SIZE_W-1:0] left;   // bytes still to send
    logic [DGM_W-1:0]  plen;   // FU-A slice length
  } desc_t;

endpackage

>>> rtl/core/h264fu_if.sv
// Channel interfaces: NAL descriptor input, packet descriptor output, config writes.
interface h264fu_nal_if;
  logic        valid;
  logic        ready;
  logic [7:0]  nal_header;
  logic [15:0] nal_size;
  logic [31:0] timestamp;
  logic        last_of_frame;
  modport source(output valid, nal_header, nal_size, timestamp, last_of_frame, input ready);
  modport sink(input valid, nal_header, nal_size, timestamp, last_of_frame, output ready);
endinterface

interface h264fu_pkt_if;
  logic        valid;
  logic        ready;
  logic [15:0] seq_num;
  logic        marker;
  logic [31:0] time_stamp;
  logic [1:0]  header_bytes;
  logic [7:0]  fu_indicator;
  logic [7:0]  fu_header;
  logic [15:0] payload_offset;
  logic [13:0] payload_len;
  logic [13:0] packet_len;
  logic        last_packet;
  modport source(output valid, seq_num, marker, time_stamp, header_bytes, fu_indicator,
                 fu_header, payload_offset, payload_len, packet_len, last_packet,
                 input ready);
  modport sink(input valid, seq_num, marker, time_stamp, header_bytes, fu_indicator,
               fu_header, payload_offset, payload_len, packet_len, last_packet,
               output ready);
endinterface

interface h264fu_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/h264_rtp_fu_a_packetizer.sv
// Top level of the H.264 RTP packetizer (single-NAL and FU-A fragmentation).
// Path: a NAL unit passes through the queue, then the sequencer load, and its
// first packet descriptor then leaves through the output register.
// Throughput: one packet per cycle while the output is not stalled; the sequencer
// loads a NAL, issues its packets (up to 61), and only then takes the next NAL.
// Reset: queue and sequencer empty, sequence counter 0, datagram length 1400.
module h264_rtp_fu_a_packetizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  h264fu_nal_if.sink    nal_i,
  h264fu_cfg_if.sink    cfg_i,
  h264fu_pkt_if.source  pkt_o
);

  h264fu_pkg::cfg_wr_t  cfg_wr;
  h264fu_pkg::desc_t    front_desc, queue_desc;
  logic                 front_valid, front_ready;
  logic                 queue_valid, queue_ready;

  // Take config writes in any cycle; issue them only while the block is idle (not enforced here).
  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  // Front end: saturate the datagram length and decide single-NAL versus FU-A.
  h264fu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .nal_i        (nal_i),
    .cfg_i        (cfg_wr),
    .desc_valid_o (front_valid),
    .desc_ready_i (front_ready),
    .desc_o       (front_desc)
  );

  // Hold up to two classified NAL units so input and output stall independently.
  h264fu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_desc),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_desc)
  );

  // Back end: slice the NAL, advance the sequence counter per packet.
  h264fu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .desc_valid_i (queue_valid),
    .desc_ready_o (queue_ready),
    .desc_i       (queue_desc),
    .pkt_o        (pkt_o)
  );

  // Marker only ever sits on the final packet of a NAL unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_o.valid |-> (!pkt_o.marker || pkt_o.last_packet))
    else $error("marker on a packet that is not the last of its NAL");

  // Single-NAL packets carry no FU bytes and start at offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_o.valid && (pkt_o.header_bytes == h264fu_pkg::HB_SINGLE)) |->
      (pkt_o.fu_indicator == 8'd0 && pkt_o.fu_header == 8'd0 &&
       pkt_o.payload_offset == 16'd0))
    else $error("single-NAL packet with FU fields set");

  // FU-A start bit matches the first slice, which begins at NAL byte 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_o.valid && (pkt_o.header_bytes == h264fu_pkg::HB_FU_A)) |->
      (pkt_o.fu_header[7] == (pkt_o.payload_offset == 16'd1)))
    else $error("FU-A start bit out of step with payload offset");

  // Packets never exceed the largest legal datagram.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_o.valid |-> (pkt_o.packet_len <= h264fu_pkg::DGM_MAX))
    else $error("packet longer than the datagram limit");

endmodule

>>> rtl/core/h264fu_front.sv
// Front end: accepts NAL descriptors and classifies them as single-NAL or FU-A.
module h264fu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  h264fu_nal_if.sink           nal_i,
  input  h264fu_pkg::cfg_wr_t  cfg_i,
  output logic                 desc_valid_o,
  input  logic                 desc_ready_i,
  output h264fu_pkg::desc_t    desc_o
);

  logic [h264fu_pkg::DGM_W-1:0]  dgm_q, dgm_d;
  logic [h264fu_pkg::DGM_W-1:0]  dgm_sat;
  logic [h264fu_pkg::SIZE_W:0]   need;
  logic                          single;

  always_comb begin
    dgm_d = dgm_q;
    if (cfg_i.valid && (cfg_i.index == h264fu_pkg::CFG_MAX_DGM)) begin
      dgm_d = cfg_i.data[h264fu_pkg::DGM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dgm_q <= h264fu_pkg::DGM_RESET;
    end else begin
      dgm_q <= dgm_d;
    end
  end

  always_comb begin
    if (dgm_q < h264fu_pkg::DGM_MIN) begin
      dgm_sat = h264fu_pkg::DGM_MIN;
    end else if (dgm_q > h264fu_pkg::DGM_MAX) begin
      dgm_sat = h264fu_pkg::DGM_MAX;
    end else begin
      dgm_sat = dgm_q;
    end
  end

  assign need   = {1'b0, nal_i.nal_size} + 17'(h264fu_pkg::RTP_HDR_LEN);
  assign single = need <= 17'(dgm_sat);

  always_comb begin
    desc_o.hdr    = nal_i.nal_header;
    desc_o.ts     = nal_i.timestamp;
    desc_o.lof    = nal_i.last_of_frame;
    desc_o.single = single;
    // Header octet travels in the FU bytes, so FU-A payload starts at byte 1.
    desc_o.left   = single ? nal_i.nal_size : (nal_i.nal_size - 16'd1);
    desc_o.plen   = dgm_sat - h264fu_pkg::FU_OVERHEAD;
  end

  assign desc_valid_o = nal_i.valid;
  assign nal_i.ready  = desc_ready_i;

endmodule

>>> rtl/core/h264fu_queue.sv
// Two-entry descriptor queue between front end and packet sequencer.
module h264fu_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  h264fu_pkg::desc_t  push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output h264fu_pkg::desc_t  pop_data_o
);

  h264fu_pkg::desc_t                 mem_q [h264fu_pkg::Q_DEPTH];
  logic [h264fu_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [h264fu_pkg::Q_CNT_W-1:0]    count_q;
  logic                              push, pop;

  assign push_ready_o = count_q != h264fu_pkg::Q_CNT_W'(h264fu_pkg::Q_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/h264fu_back.sv
// Back end: walks one NAL descriptor and issues its packet descriptors.
module h264fu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  h264fu_pkg::cfg_wr_t  cfg_i,
  input  logic                 desc_valid_i,
  output logic                 desc_ready_o,
  input  h264fu_pkg::desc_t    desc_i,
  h264fu_pkt_if.source         pkt_o
);

  h264fu_pkg::desc_t                work_q;
  logic                             busy_q;
  logic                             first_q;
  logic [h264fu_pkg::SIZE_W-1:0]    left_q;
  logic [h264fu_pkg::SIZE_W-1:0]    off_q;
  logic [h264fu_pkg::SEQ_W-1:0]     seq_q;

  logic                             out_valid_q;
  logic [h264fu_pkg::SEQ_W-1:0]     o_seq_q;
  logic                             o_marker_q;
  logic [h264fu_pkg::TS_W-1:0]      o_ts_q;
  logic [1:0]                       o_hb_q;
  logic [7:0]                       o_ind_q, o_fh_q;
  logic [h264fu_pkg::SIZE_W-1:0]    o_off_q;
  logic [h264fu_pkg::DGM_W-1:0]     o_plen_q, o_pktlen_q;
  logic                             o_last_q;

  logic                             emit, load, gt, last;
  logic [h264fu_pkg::DGM_W-1:0]     len;
  logic [1:0]                       hb;

  assign load         = !busy_q && desc_valid_i;
  assign desc_ready_o = !busy_q;
  assign emit         = busy_q && (!out_valid_q || pkt_o.ready);

  always_comb begin
    gt = left_q > 16'(work_q.plen);
    if (work_q.single) begin
      len  = left_q[h264fu_pkg::DGM_W-1:0];
      last = 1'b1;
      hb   = h264fu_pkg::HB_SINGLE;
    end else begin
      len  = gt ? work_q.plen : left_q[h264fu_pkg::DGM_W-1:0];
      last = !gt;
      hb   = h264fu_pkg::HB_FU_A;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      seq_q       <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit && last) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pkt_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid && (cfg_i.index == h264fu_pkg::CFG_SEQ_START)) begin
        seq_q <= cfg_i.data;
      end else if (emit) begin
        seq_q <= seq_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q  <= desc_i;
      left_q  <= desc_i.left;
      off_q   <= 16'd1;
      first_q <= 1'b1;
    end else if (emit) begin
      left_q  <= left_q - 16'(len);
      off_q   <= off_q + 16'(len);
      first_q <= 1'b0;
    end
    if (emit) begin
      o_seq_q    <= seq_q;
      o_marker_q <= last & work_q.lof;
      o_ts_q     <= work_q.ts;
      o_hb_q     <= hb;
      o_ind_q    <= work_q.single ? 8'd0
                    : ((work_q.hdr & h264fu_pkg::NRI_F_MASK) | h264fu_pkg::FU_A_TYPE);
      o_fh_q     <= work_q.single ? 8'd0
                    : ((work_q.hdr & h264fu_pkg::TYPE_MASK) | {first_q, last, 6'd0});
      o_off_q    <= work_q.single ? 16'd0 : off_q;
      o_plen_q   <= len;
      o_pktlen_q <= h264fu_pkg::RTP_HDR_LEN + 14'(hb) + len;
      o_last_q   <= last;
    end
  end

  assign pkt_o.valid          = out_valid_q;
  assign pkt_o.seq_num        = o_seq_q;
  assign pkt_o.marker         = o_marker_q;
  assign pkt_o.time_stamp     = o_ts_q;
  assign pkt_o.header_bytes   = o_hb_q;
  assign pkt_o.fu_indicator   = o_ind_q;
  assign pkt_o.fu_header      = o_fh_q;
  assign pkt_o.payload_offset = o_off_q;
  assign pkt_o.payload_len    = o_plen_q;
  assign pkt_o.packet_len     = o_pktlen_q;
  assign pkt_o.last_packet    = o_last_q;

endmodule
